### rtl/icrt_pkg.sv
// icrt_pkg: shared types and codes for the inode cache reference-count table.
// Holds the table entry layout, result status codes and controller states.
// No dependencies; imported by icrt_table and inode_cache_refcount_table_core.
`default_nettype none

package icrt_pkg;

  // one cached inode entry as held in the table memory
  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] inode;
    logic [7:0]  refs;
    logic        dirty;
  } entry_t;

  // request opcodes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    STS_HIT      = 3'd0,
    STS_LOAD     = 3'd1,
    STS_FULL     = 3'd2,
    STS_HELD     = 3'd3,
    STS_CLEAN    = 3'd4,
    STS_WRITE    = 3'd5,
    STS_IDLE_PUT = 3'd6
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUT
  } state_t;

  // configuration register indexes (word address bits above the byte offset)
  localparam logic REG_TABLE_START = 1'b0;

  // slot widened far enough to compare against any legal table size
  localparam int SLOT_EXT_W = 9;

  // inodes per disk block is eight: shift and mask width
  localparam int INO_SHIFT = 3;

endpackage

`default_nettype wire

### rtl/icrt_table.sv
// icrt_table: entry memory of the inode cache, one read and one write port.
// Read data is registered; entries never written read as all zero via valid bits.
// Depends on icrt_pkg for the entry layout.
`default_nettype none

module icrt_table #(
  parameter int TABLE_ENTRIES = 64,
  parameter int IW            = 6
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [IW-1:0]   rd_addr,
  output icrt_pkg::entry_t     rd_entry,
  input  wire logic            wr_en,
  input  wire logic [IW-1:0]   wr_addr,
  input  icrt_pkg::entry_t     wr_entry
);
  import icrt_pkg::*;

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  entry_t                   rd_q_r;
  logic                     rd_vld_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // per-entry valid marks, cleared together at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // an unwritten entry reads as the reset value
  assign rd_entry = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

### rtl/inode_cache_refcount_table_core.sv
// inode_cache_refcount_table_core: top level of the reference-counted inode cache.
// Depends on icrt_pkg and icrt_table (entry memory).
//
// Usage:
//   A request word is taken at a clock edge with start high and busy low.
//   in_cmd selects get (look up device and inode, take a reference, allocate
//   the lowest idle entry on a miss) or put (release a reference on in_slot).
//   Exactly one result word follows each request: out_valid is high for one
//   cycle with the status, slot, count and, for load and write-back, the disk
//   block and offset. The receiver cannot hold results off.
//   Timing: a get walks the table one entry a cycle through the memory read
//   port, stopping at the first match. A put is one read and one write.
//   busy drops in the cycle the result is shown, so the next request may be
//   taken alongside it.
//   The APB register at byte address 0 holds the first block of the on-disk
//   inode table; the user must write it only while the block is idle, as
//   the block itself does not enforce this.
//   Reset (rst_n low, synchronous) empties the table through per-entry
//   valid marks and clears the register; no clearing pass is needed.
`default_nettype none

module inode_cache_refcount_table_core #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_device,
  input  wire logic [31:0] in_inode_number,
  input  wire logic [5:0]  in_slot,
  input  wire logic        in_mark_modified,
  // result channel
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [5:0]       out_result_slot,
  output logic [7:0]       out_ref_count,
  output logic [31:0]      out_disk_block,
  output logic [2:0]       out_block_offset,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import icrt_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [SLOT_EXT_W-1:0] ENTRIES_EXT = SLOT_EXT_W'(TABLE_ENTRIES);

  state_t          state_r, state_nxt;

  // request holding registers
  logic [7:0]      req_dev_r;
  logic [31:0]     req_ino_r;
  logic [31:0]     req_pos_r;
  logic [5:0]      req_slot_r;
  logic            req_mod_r;
  logic            req_inrange_r;

  // scan bookkeeping
  logic [IW-1:0]   cnt_r, cnt_nxt;
  logic            free_found_r, free_found_nxt;
  logic [IW-1:0]   free_idx_r, free_idx_nxt;

  // result registers
  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  logic [5:0]      out_slot_r, out_slot_nxt;
  logic [7:0]      out_count_r, out_count_nxt;
  logic            out_loc_r, out_loc_nxt;
  logic [31:0]     out_pos_r, out_pos_nxt;

  logic [31:0]     table_start_r;

  // memory port signals
  logic [IW-1:0]   rd_addr;
  entry_t          rd_entry;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  entry_t          wr_entry;

  logic            accept;
  logic [SLOT_EXT_W-1:0] slot_ext;
  logic            scan_match;
  logic            scan_free;
  logic            scan_last;
  logic            put_live;
  logic [7:0]      put_refs;
  logic            put_dirty;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign slot_ext = SLOT_EXT_W'(in_slot);

  // entry memory
  icrt_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IW           (IW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_entry(rd_entry),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_entry(wr_entry)
  );

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_start_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TABLE_START)) begin
      table_start_r <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_TABLE_START) ? table_start_r : '0;

  // conditions on the entry coming out of the memory
  assign scan_match = (rd_entry.device == req_dev_r) && (rd_entry.inode == req_ino_r);
  assign scan_free  = (rd_entry.refs == 8'd0);
  assign scan_last  = (cnt_r == LAST_IDX);
  assign put_live   = req_inrange_r && (rd_entry.refs != 8'd0);
  assign put_refs   = rd_entry.refs - 8'd1;
  assign put_dirty  = rd_entry.dirty | req_mod_r;

  // read address: first entry or the named slot on accept, next entry while scanning
  always_comb begin
    rd_addr = '0;
    unique case (state_r)
      ST_IDLE: rd_addr = (accept && (in_cmd == CMD_PUT)) ? slot_ext[IW-1:0] : '0;
      ST_SCAN: rd_addr = cnt_r + 1'b1;
      ST_PUT:  rd_addr = '0;
      default: rd_addr = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_cmd == CMD_PUT) ? ST_PUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_match || scan_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the controller: table write-back, scan tracking and result word
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = cnt_r;
    wr_entry       = rd_entry;
    cnt_nxt        = cnt_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    out_loc_nxt    = out_loc_r;
    out_pos_nxt    = out_pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt        = '0;
          free_found_nxt = 1'b0;
          free_idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (scan_match) begin
          // hit: raise the count, saturating at the top
          wr_en          = 1'b1;
          wr_entry.refs  = (rd_entry.refs == 8'hFF) ? 8'hFF : rd_entry.refs + 8'd1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_HIT;
          out_slot_nxt   = 6'(cnt_r);
          out_count_nxt  = wr_entry.refs;
          out_loc_nxt    = 1'b0;
        end else if (scan_last) begin
          out_valid_nxt = 1'b1;
          if (free_found_r || scan_free) begin
            // miss: claim the lowest idle entry
            wr_en          = 1'b1;
            wr_addr        = free_found_r ? free_idx_r : cnt_r;
            wr_entry       = '{device: req_dev_r, inode: req_ino_r, refs: 8'd1, dirty: 1'b0};
            out_status_nxt = STS_LOAD;
            out_slot_nxt   = 6'(wr_addr);
            out_count_nxt  = 8'd1;
            out_loc_nxt    = 1'b1;
            out_pos_nxt    = req_pos_r;
          end else begin
            out_status_nxt = STS_FULL;
            out_slot_nxt   = '0;
            out_count_nxt  = '0;
            out_loc_nxt    = 1'b0;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          if (scan_free && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cnt_r;
          end
        end
      end
      ST_PUT: begin
        out_valid_nxt = 1'b1;
        out_slot_nxt  = req_slot_r;
        out_loc_nxt   = 1'b0;
        wr_addr       = IW'(req_slot_r);
        if (!put_live) begin
          out_status_nxt = STS_IDLE_PUT;
          out_count_nxt  = '0;
        end else begin
          wr_en          = 1'b1;
          wr_entry.refs  = put_refs;
          wr_entry.dirty = put_dirty;
          out_count_nxt  = put_refs;
          if (put_refs != 8'd0) begin
            out_status_nxt = STS_HELD;
          end else if (!put_dirty) begin
            out_status_nxt = STS_CLEAN;
          end else begin
            out_status_nxt = STS_WRITE;
            out_loc_nxt    = 1'b1;
            out_pos_nxt    = rd_entry.inode - 32'd1;
          end
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      free_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      free_found_r <= free_found_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
    out_loc_r    <= out_loc_nxt;
    out_pos_r    <= out_pos_nxt;
    if (accept) begin
      req_dev_r     <= in_device;
      req_ino_r     <= in_inode_number;
      req_pos_r     <= in_inode_number - 32'd1;
      req_slot_r    <= in_slot;
      req_mod_r     <= in_mark_modified;
      req_inrange_r <= (slot_ext < ENTRIES_EXT);
    end
  end

  // result word
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_slot  = out_slot_r;
  assign out_ref_count    = out_count_r;
  assign out_disk_block   = out_loc_r ?
                            table_start_r + {{INO_SHIFT{1'b0}}, out_pos_r[31:INO_SHIFT]} : '0;
  assign out_block_offset = out_loc_r ? out_pos_r[INO_SHIFT-1:0] : '0;

  // checks
  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) != ST_IDLE))
    else $error("result word without a request in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r <= LAST_IDX))
    else $error("scan index beyond the table");

  a_full_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STS_FULL)) |->
      ((out_result_slot == 6'd0) && (out_ref_count == 8'd0) && (out_disk_block == 32'd0)))
    else $error("table full result carries entry data");

  a_write_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_valid)
    else $error("table write without a result");

endmodule

`default_nettype wire
